@@ rtl/tfn_pkg.sv @@
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared widths for the triangle face normal pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tfn_pkg;

   // normalized magnitudes: the largest in [2^30, 2^31) if nonzero, rest no larger
   localparam int unsigned NORM_W    = 31;
   localparam int unsigned NORM_MSB  = 30;
   // sum of three normalized squares, and its integer root
   localparam int unsigned SUM_W     = 64;
   localparam int unsigned LEN_W     = 32;
   // exact degenerate test only runs on magnitudes below 2^16
   localparam int unsigned SMALL_W   = 16;
   localparam int unsigned MIN_W     = 16;
   localparam int unsigned OUT_W     = 16;
   localparam logic [OUT_W-1:0] OUT_POS_MAX = 16'h7fff;
   localparam logic [OUT_W-1:0] OUT_NEG_MAX = 16'h8000;

endpackage

`default_nettype wire

@@ rtl/tfn_if.sv @@
// ----------------------------------------------------------------------------
// tfn_if
// Valid/ready channels: triangle beats in, normal beats out.
// ----------------------------------------------------------------------------
`default_nettype none

interface tfn_req_if #(
   parameter int unsigned COORD_WIDTH = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] v1_x;
   logic signed [COORD_WIDTH-1:0] v1_y;
   logic signed [COORD_WIDTH-1:0] v1_z;
   logic signed [COORD_WIDTH-1:0] v2_x;
   logic signed [COORD_WIDTH-1:0] v2_y;
   logic signed [COORD_WIDTH-1:0] v2_z;
   logic signed [COORD_WIDTH-1:0] v3_x;
   logic signed [COORD_WIDTH-1:0] v3_y;
   logic signed [COORD_WIDTH-1:0] v3_z;

   modport source (output valid, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, v3_x, v3_y, v3_z,
                   input ready);
   modport sink   (input valid, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, v3_x, v3_y, v3_z,
                   output ready);
endinterface

interface tfn_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [15:0] normal_x;
   logic signed [15:0] normal_y;
   logic signed [15:0] normal_z;
   logic              degenerate;

   modport source (output valid, normal_x, normal_y, normal_z, degenerate, input ready);
   modport sink   (input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

`default_nettype wire

@@ rtl/tfn_cross.sv @@
// ----------------------------------------------------------------------------
// tfn_cross
// Edge vectors, partial products and cross product, three stages.
// ----------------------------------------------------------------------------
`default_nettype none

module tfn_cross #(
   parameter int unsigned COORD_WIDTH = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          adv,
   input  wire logic                          in_valid,
   input  wire logic signed [COORD_WIDTH-1:0] v1 [3],
   input  wire logic signed [COORD_WIDTH-1:0] v2 [3],
   input  wire logic signed [COORD_WIDTH-1:0] v3 [3],
   output logic                               out_valid,
   output logic signed [2*COORD_WIDTH+2:0]    n_out [3]
);

   localparam int unsigned DW = COORD_WIDTH + 1;
   localparam int unsigned PW = 2 * DW;
   localparam int unsigned NW = PW + 1;

   logic signed [DW-1:0] a_ff [3], a_in [3];
   logic signed [DW-1:0] b_ff [3], b_in [3];
   logic signed [PW-1:0] p_ff [6], p_in [6];
   logic signed [NW-1:0] n_ff [3], n_in [3];
   logic [2:0]           val_ff, val_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         a_in[i] = DW'(v2[i]) - DW'(v1[i]);
         b_in[i] = DW'(v3[i]) - DW'(v1[i]);
      end
      // x: ay*bz - az*by, y: az*bx - ax*bz, z: ax*by - ay*bx
      p_in[0] = PW'(a_ff[1]) * PW'(b_ff[2]);
      p_in[1] = PW'(a_ff[2]) * PW'(b_ff[1]);
      p_in[2] = PW'(a_ff[2]) * PW'(b_ff[0]);
      p_in[3] = PW'(a_ff[0]) * PW'(b_ff[2]);
      p_in[4] = PW'(a_ff[0]) * PW'(b_ff[1]);
      p_in[5] = PW'(a_ff[1]) * PW'(b_ff[0]);
      for (int i = 0; i < 3; i++) begin
         n_in[i] = NW'(p_ff[2*i]) - NW'(p_ff[2*i+1]);
      end
      val_in = {val_ff[1:0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff <= '0;
      end else if (adv) begin
         val_ff <= val_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff <= a_in;
         b_ff <= b_in;
         p_ff <= p_in;
         n_ff <= n_in;
      end
   end

   assign out_valid = val_ff[2];
   assign n_out     = n_ff;

endmodule

`default_nettype wire

@@ rtl/tfn_norm.sv @@
// ----------------------------------------------------------------------------
// tfn_norm
// Magnitudes, leading-one search, scaling so the largest lies in [2^30, 2^31),
// squares, their sum and the exact degenerate test.
// ----------------------------------------------------------------------------
`default_nettype none

module tfn_norm #(
   parameter int unsigned COORD_WIDTH = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  adv,
   input  wire logic                                  in_valid,
   input  wire logic signed [2*COORD_WIDTH+2:0]       n_in [3],
   input  wire logic [tfn_pkg::MIN_W-1:0]             min_length,
   output logic                                       out_valid,
   output logic [tfn_pkg::SUM_W-1:0]                  sum_out,
   output logic [tfn_pkg::NORM_W-1:0]                 m_out [3],
   output logic [2:0]                                 neg_out,
   output logic                                       degen_out
);

   localparam int unsigned NW   = 2 * COORD_WIDTH + 3;
   localparam int unsigned MW   = NW - 1;
   localparam int unsigned POSW = $clog2(MW);
   localparam int unsigned WW   = (MW > tfn_pkg::NORM_W) ? MW : tfn_pkg::NORM_W;
   localparam int unsigned SQW  = 2 * tfn_pkg::SMALL_W;
   localparam int unsigned BQW  = 2 * tfn_pkg::NORM_W;

   // stage 1: magnitudes
   logic [MW-1:0]   mag1_ff [3], mag1_in [3];
   logic [2:0]      neg1_ff, neg1_in;
   // stage 2: max and leading-one position
   logic [MW-1:0]   mag2_ff [3];
   logic [2:0]      neg2_ff;
   logic [MW-1:0]   mx2_ff, mx2_in;
   logic [POSW-1:0] pos2_ff, pos2_in;
   // stage 3: scaled values, small squares
   logic [tfn_pkg::NORM_W-1:0] m3_ff [3], m3_in [3];
   logic [SQW-1:0]  sq3_ff [3], sq3_in [3];
   logic            small3_ff, small3_in;
   logic [2:0]      neg3_ff;
   // stage 4: big squares, degenerate test
   logic [BQW-1:0]  bq4_ff [3], bq4_in [3];
   logic [tfn_pkg::NORM_W-1:0] m4_ff [3];
   logic [2:0]      neg4_ff;
   logic            degen4_ff, degen4_in;
   // stage 5: sum
   logic [tfn_pkg::SUM_W-1:0] sum5_ff, sum5_in;
   logic [tfn_pkg::NORM_W-1:0] m5_ff [3];
   logic [2:0]      neg5_ff;
   logic            degen5_ff;
   logic [4:0]      val_ff, val_in;

   logic [WW-1:0]   ext_mag [3];
   logic [SQW+1:0]  small_sum;
   logic [SQW-1:0]  min_sq;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         neg1_in[i] = n_in[i][NW-1];
         mag1_in[i] = n_in[i][NW-1] ? MW'(-n_in[i]) : MW'(n_in[i]);
      end

      mx2_in = mag1_ff[0];
      for (int i = 1; i < 3; i++) begin
         if (mag1_ff[i] > mx2_in) begin
            mx2_in = mag1_ff[i];
         end
      end
      pos2_in = '0;
      for (int k = 0; k < MW; k++) begin
         if (mx2_in[k]) begin
            pos2_in = POSW'(k);
         end
      end

      small3_in = (mx2_ff[MW-1:tfn_pkg::SMALL_W] == '0);
      for (int i = 0; i < 3; i++) begin
         ext_mag[i] = WW'(mag2_ff[i]);
         if (32'(pos2_ff) > tfn_pkg::NORM_MSB) begin
            m3_in[i] = tfn_pkg::NORM_W'(ext_mag[i] >> (32'(pos2_ff) - tfn_pkg::NORM_MSB));
         end else begin
            m3_in[i] = tfn_pkg::NORM_W'(ext_mag[i] << (tfn_pkg::NORM_MSB - 32'(pos2_ff)));
         end
         sq3_in[i] = SQW'(mag2_ff[i][tfn_pkg::SMALL_W-1:0])
                   * SQW'(mag2_ff[i][tfn_pkg::SMALL_W-1:0]);
      end

      for (int i = 0; i < 3; i++) begin
         bq4_in[i] = BQW'(m3_ff[i]) * BQW'(m3_ff[i]);
      end
      small_sum = (SQW+2)'(sq3_ff[0]) + (SQW+2)'(sq3_ff[1]) + (SQW+2)'(sq3_ff[2]);
      min_sq    = SQW'(min_length) * SQW'(min_length);
      degen4_in = small3_ff && (small_sum <= (SQW+2)'(min_sq));

      sum5_in = tfn_pkg::SUM_W'(bq4_ff[0]) + tfn_pkg::SUM_W'(bq4_ff[1])
              + tfn_pkg::SUM_W'(bq4_ff[2]);

      val_in = {val_ff[3:0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff <= '0;
      end else if (adv) begin
         val_ff <= val_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mag1_ff   <= mag1_in;
         neg1_ff   <= neg1_in;
         mag2_ff   <= mag1_ff;
         neg2_ff   <= neg1_ff;
         mx2_ff    <= mx2_in;
         pos2_ff   <= pos2_in;
         m3_ff     <= m3_in;
         sq3_ff    <= sq3_in;
         small3_ff <= small3_in;
         neg3_ff   <= neg2_ff;
         bq4_ff    <= bq4_in;
         m4_ff     <= m3_ff;
         neg4_ff   <= neg3_ff;
         degen4_ff <= degen4_in;
         sum5_ff   <= sum5_in;
         m5_ff     <= m4_ff;
         neg5_ff   <= neg4_ff;
         degen5_ff <= degen4_ff;
      end
   end

   assign out_valid = val_ff[4];
   assign sum_out   = sum5_ff;
   assign m_out     = m5_ff;
   assign neg_out   = neg5_ff;
   assign degen_out = degen5_ff;

endmodule

`default_nettype wire

@@ rtl/tfn_sqrt.sv @@
// ----------------------------------------------------------------------------
// tfn_sqrt
// Pipelined integer square root, one result bit per stage, with sideband.
// ----------------------------------------------------------------------------
`default_nettype none

module tfn_sqrt #(
   parameter int unsigned SB_W = 8
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         adv,
   input  wire logic                         in_valid,
   input  wire logic [tfn_pkg::SUM_W-1:0]    radicand,
   input  wire logic [SB_W-1:0]              sb_in,
   output logic                              out_valid,
   output logic [tfn_pkg::LEN_W-1:0]         root,
   output logic [SB_W-1:0]                   sb_out
);

   localparam int unsigned NST = tfn_pkg::LEN_W;
   localparam int unsigned W   = tfn_pkg::SUM_W;

   logic [W-1:0]    v_ff  [NST+1];
   logic [W-1:0]    r_ff  [NST+1];
   logic [SB_W-1:0] sb_ff [NST+1];
   logic            val_ff [NST+1];
   logic [W-1:0]    v_in  [NST];
   logic [W-1:0]    r_in  [NST];

   assign v_ff[0]   = radicand;
   assign r_ff[0]   = '0;
   assign sb_ff[0]  = sb_in;
   assign val_ff[0] = in_valid;

   for (genvar k = 0; k < NST; k++) begin : g_stage
      localparam logic [W-1:0] BITV = W'(1) << (W - 2 - 2 * k);

      always_comb begin
         if (v_ff[k] >= r_ff[k] + BITV) begin
            v_in[k] = v_ff[k] - (r_ff[k] + BITV);
            r_in[k] = (r_ff[k] >> 1) + BITV;
         end else begin
            v_in[k] = v_ff[k];
            r_in[k] = r_ff[k] >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            val_ff[k+1] <= 1'b0;
         end else if (adv) begin
            val_ff[k+1] <= val_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            v_ff[k+1]  <= v_in[k];
            r_ff[k+1]  <= r_in[k];
            sb_ff[k+1] <= sb_ff[k];
         end
      end
   end

   assign out_valid = val_ff[NST];
   assign root      = r_ff[NST][tfn_pkg::LEN_W-1:0];
   assign sb_out    = sb_ff[NST];

endmodule

`default_nettype wire

@@ rtl/tfn_div.sv @@
// ----------------------------------------------------------------------------
// tfn_div
// Pipelined restoring divider: round(m * 2^F / len), one quotient bit per
// stage, with sideband.
// ----------------------------------------------------------------------------
`default_nettype none

module tfn_div #(
   parameter int unsigned FRAC_BITS = 14,
   parameter int unsigned SB_W      = 2
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          adv,
   input  wire logic                          in_valid,
   input  wire logic [tfn_pkg::NORM_W-1:0]    m,
   input  wire logic [tfn_pkg::LEN_W-1:0]     len,
   input  wire logic [SB_W-1:0]               sb_in,
   output logic                               out_valid,
   output logic [FRAC_BITS+1:0]               quot,
   output logic [SB_W-1:0]                    sb_out
);

   localparam int unsigned QB = FRAC_BITS + 2;
   localparam int unsigned RW = FRAC_BITS + tfn_pkg::LEN_W + 2;

   logic [RW-1:0]                rem_ff [QB+1];
   logic [tfn_pkg::LEN_W-1:0]    d_ff   [QB+1];
   logic [QB-1:0]                q_ff   [QB+1];
   logic [SB_W-1:0]              sb_ff  [QB+1];
   logic                         val_ff [QB+1];
   logic [RW-1:0]                rem_in [QB];
   logic [QB-1:0]                q_in   [QB];
   logic [RW-1:0]                num_in;

   // stage 0: rounded numerator
   assign num_in = (RW'(m) << FRAC_BITS) + RW'(len >> 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff[0] <= 1'b0;
      end else if (adv) begin
         val_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= num_in;
         d_ff[0]   <= len;
         q_ff[0]   <= '0;
         sb_ff[0]  <= sb_in;
      end
   end

   for (genvar j = 0; j < QB; j++) begin : g_stage
      localparam int unsigned SH = QB - 1 - j;
      logic [RW-1:0] dsh;

      always_comb begin
         dsh = RW'(d_ff[j]) << SH;
         q_in[j] = q_ff[j];
         if (rem_ff[j] >= dsh) begin
            rem_in[j]   = rem_ff[j] - dsh;
            q_in[j][SH] = 1'b1;
         end else begin
            rem_in[j] = rem_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            val_ff[j+1] <= 1'b0;
         end else if (adv) begin
            val_ff[j+1] <= val_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[j+1] <= rem_in[j];
            d_ff[j+1]   <= d_ff[j];
            q_ff[j+1]   <= q_in[j];
            sb_ff[j+1]  <= sb_ff[j];
         end
      end
   end

   assign out_valid = val_ff[QB];
   assign quot      = q_ff[QB];
   assign sb_out    = sb_ff[QB];

endmodule

`default_nettype wire

@@ rtl/triangle_face_normal.sv @@
// ----------------------------------------------------------------------------
// triangle_face_normal
// Unit face normal of one triangle per beat, Q7.8 vertices in, Q1.14 out.
// ----------------------------------------------------------------------------
// Takes one triangle beat per clock and returns one normal beat per triangle,
// in order. The stages are the cross product (3), scaling and squares (5), a
// 32-stage square root, a numerator stage plus one divider stage per quotient
// bit, and the output register. Throughput is one beat per clock while rsp
// is taken; a stall on rsp freezes the whole pipe. The normal is
// e1 x e2 with e1 = v2 - v1, e2 = v3 - v1; if its length is at or below
// csr min_length (2^-16 units) the beat carries a zero vector and degenerate.
// Write csr only while the pipe is empty.
`default_nettype none

module triangle_face_normal #(
   parameter int unsigned COORD_WIDTH      = 16,
   parameter int unsigned NORMAL_FRAC_BITS = 14
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   tfn_req_if.sink                          req_ch,
   tfn_rsp_if.source                        rsp_ch,
   input  wire logic                        csr_wr_en,
   input  wire logic [tfn_pkg::MIN_W-1:0]   csr_wr_data
);

   localparam int unsigned NW  = 2 * COORD_WIDTH + 3;
   localparam int unsigned QB  = NORMAL_FRAC_BITS + 2;
   localparam int unsigned MNW = tfn_pkg::NORM_W;
   localparam int unsigned SBW = 3 * MNW + 4;

   logic [tfn_pkg::MIN_W-1:0] min_length_ff;

   // one enable for the whole pipe: move when the output slot is free or taken
   logic adv;
   logic out_valid_ff, out_valid_in;

   logic signed [COORD_WIDTH-1:0] v1 [3], v2 [3], v3 [3];
   logic                          x_valid;
   logic signed [NW-1:0]          x_n [3];

   logic                          n_valid;
   logic [tfn_pkg::SUM_W-1:0]     n_sum;
   logic [MNW-1:0]                n_m [3];
   logic [2:0]                    n_neg;
   logic                          n_degen;

   logic                          s_valid;
   logic [tfn_pkg::LEN_W-1:0]     s_len;
   logic [SBW-1:0]                s_sb_in, s_sb;

   logic [2:0]                    d_valid;
   logic [QB-1:0]                 d_q  [3];
   logic [1:0]                    d_sb [3];

   logic signed [tfn_pkg::OUT_W-1:0] nrm_ff [3], nrm_in [3];
   logic                             degen_ff, degen_in;
   logic [31:0]                      qe [3];

   assign adv          = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_length_ff <= '0;
      end else if (csr_wr_en) begin
         min_length_ff <= csr_wr_data;
      end
   end

   assign v1 = '{req_ch.v1_x, req_ch.v1_y, req_ch.v1_z};
   assign v2 = '{req_ch.v2_x, req_ch.v2_y, req_ch.v2_z};
   assign v3 = '{req_ch.v3_x, req_ch.v3_y, req_ch.v3_z};

   tfn_cross #(.COORD_WIDTH(COORD_WIDTH)) u_cross (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_ch.valid),
      .v1        (v1),
      .v2        (v2),
      .v3        (v3),
      .out_valid (x_valid),
      .n_out     (x_n)
   );

   tfn_norm #(.COORD_WIDTH(COORD_WIDTH)) u_norm (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_valid   (x_valid),
      .n_in       (x_n),
      .min_length (min_length_ff),
      .out_valid  (n_valid),
      .sum_out    (n_sum),
      .m_out      (n_m),
      .neg_out    (n_neg),
      .degen_out  (n_degen)
   );

   // sideband rides the root pipe: degenerate, signs, scaled magnitudes
   assign s_sb_in = {n_degen, n_neg, n_m[2], n_m[1], n_m[0]};

   tfn_sqrt #(.SB_W(SBW)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (n_valid),
      .radicand  (n_sum),
      .sb_in     (s_sb_in),
      .out_valid (s_valid),
      .root      (s_len),
      .sb_out    (s_sb)
   );

   // three dividers in lockstep, one per component
   for (genvar i = 0; i < 3; i++) begin : g_div
      tfn_div #(.FRAC_BITS(NORMAL_FRAC_BITS), .SB_W(2)) u_div (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (s_valid),
         .m         (s_sb[i*MNW +: MNW]),
         .len       (s_len),
         .sb_in     ({s_sb[SBW-1], s_sb[3*MNW+i]}),
         .out_valid (d_valid[i]),
         .quot      (d_q[i]),
         .sb_out    (d_sb[i])
      );
   end

   // output stage: sign, saturate, zero on degenerate
   always_comb begin
      degen_in     = d_sb[0][1];
      out_valid_in = d_valid[0];
      for (int i = 0; i < 3; i++) begin
         qe[i] = 32'(d_q[i]);
         if (degen_in) begin
            nrm_in[i] = '0;
         end else if (d_sb[i][0]) begin
            nrm_in[i] = (qe[i] > 32'd32768) ? tfn_pkg::OUT_NEG_MAX
                                            : tfn_pkg::OUT_W'(32'h10000 - qe[i]);
         end else begin
            nrm_in[i] = (qe[i] > 32'd32767) ? tfn_pkg::OUT_POS_MAX
                                            : tfn_pkg::OUT_W'(qe[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         nrm_ff   <= nrm_in;
         degen_ff <= degen_in;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.normal_x   = nrm_ff[0];
   assign rsp_ch.normal_y   = nrm_ff[1];
   assign rsp_ch.normal_z   = nrm_ff[2];
   assign rsp_ch.degenerate = degen_ff;

`ifndef NO_ASSERTIONS
   // a degenerate beat carries the zero vector
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && degen_ff |-> nrm_ff[0] == '0 && nrm_ff[1] == '0 && nrm_ff[2] == '0)
      else $error("degenerate beat with nonzero normal");

   // a good normal always has a nonzero component
   a_nondegen_nonzero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !degen_ff |-> nrm_ff[0] != '0 || nrm_ff[1] != '0 || nrm_ff[2] != '0)
      else $error("nondegenerate beat with zero normal");

   // the three dividers stay in lockstep
   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      d_valid[0] == d_valid[1] && d_valid[1] == d_valid[2])
      else $error("divider lanes out of step");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !out_valid_ff)
      else $error("output valid right after reset");
`endif

endmodule

`default_nettype wire
